// File: hdl/ppic_pkg.sv
// Shared types, widths and constants for the pose reprojection inlier counter.
// Used by ppic_front, ppic_back, the top level and the bench; depends on nothing.
package ppic_pkg;

    // Field widths.
    localparam int WORLD_W = 32;
    localparam int RAY_W   = 24;
    localparam int ROT_W   = 16;
    localparam int ROW_W   = 48;
    localparam int TRANS_W = 32;
    localparam int THR_W   = 24;
    localparam int ERR_W   = 48;
    localparam int CNT_W   = 17;

    // Internal datapath widths.
    localparam int PROD_W  = ROT_W + WORLD_W;        // rotation times world coordinate
    localparam int ACC_W   = 50;                     // Q.30 sum of one rotation row
    localparam int P_W     = 35;                     // transformed coordinate, Q.16
    localparam int DPROD_W = P_W + RAY_W;            // one term of the dot product
    localparam int DOT_W   = DPROD_W + 2;            // the whole dot product
    localparam int DEN_W   = P_W;                    // divisor magnitude
    localparam int NUM_W   = P_W + 24;               // dividend magnitude, shifted by 24
    localparam int Q_W     = NUM_W + 1;              // signed quotient
    localparam int DX_W    = Q_W + 1;                // signed projected difference
    localparam int SQ_W    = 64;                     // one squared difference

    // Configuration space: 64-bit registers at eight-byte spacing.
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;

    localparam logic [ERR_W-1:0] ERR_MAX       = '1;
    localparam int               CNT_FIELD_MAX = 131071;
    localparam int               MAX_POINTS_DEF = 65536;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_ROT_ROW0  = 3'd0,
        REG_ROT_ROW1  = 3'd1,
        REG_ROT_ROW2  = 3'd2,
        REG_TRANS_X   = 3'd3,
        REG_TRANS_Y   = 3'd4,
        REG_TRANS_Z   = 3'd5,
        REG_THRESHOLD = 3'd6,
        REG_UNUSED    = 3'd7
    } t_reg_idx;

    // Pose and threshold as seen by the compute engine.
    typedef struct packed {
        logic [ROW_W-1:0]          rot_row0;
        logic [ROW_W-1:0]          rot_row1;
        logic [ROW_W-1:0]          rot_row2;
        logic signed [TRANS_W-1:0] trans_x;
        logic signed [TRANS_W-1:0] trans_y;
        logic signed [TRANS_W-1:0] trans_z;
        logic [THR_W-1:0]          threshold;
    } t_cfg;

    // One queued correspondence with its front-end classification.
    typedef struct packed {
        logic signed [WORLD_W-1:0] world_x;
        logic signed [WORLD_W-1:0] world_y;
        logic signed [WORLD_W-1:0] world_z;
        logic signed [RAY_W-1:0]   ray_x;
        logic signed [RAY_W-1:0]   ray_y;
        logic signed [RAY_W-1:0]   ray_z;
        logic                      last;
        logic                      ray_z_zero;
    } t_qitem;

    // Compute engine states.
    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_SUM,
        B_DOTM,
        B_DOTS,
        B_DIVGO,
        B_DIVW,
        B_DIFF,
        B_SQ,
        B_FIN,
        B_EMIT
    } t_bstate;

endpackage

// File: hdl/ppic_queue.sv
// Small register-based first-in first-out queue between front and back end.
// Depends on nothing.
module ppic_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage is written only on a push.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap at the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: hdl/ppic_front.sv
// Front end: accepts correspondences, classifies them and queues them.
// Depends on ppic_pkg and ppic_queue.
module ppic_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [ppic_pkg::WORLD_W-1:0] i_world_x,
    input  logic signed [ppic_pkg::WORLD_W-1:0] i_world_y,
    input  logic signed [ppic_pkg::WORLD_W-1:0] i_world_z,
    input  logic signed [ppic_pkg::RAY_W-1:0]   i_ray_x,
    input  logic signed [ppic_pkg::RAY_W-1:0]   i_ray_y,
    input  logic signed [ppic_pkg::RAY_W-1:0]   i_ray_z,
    input  logic                           i_last,
    input  logic                           i_pop,
    output logic                           o_head_valid,
    output ppic_pkg::t_qitem               o_head
);
    ppic_pkg::t_qitem w_item;
    logic             w_full;
    logic             w_push;

    // An observed ray with no depth cannot be projected.
    always_comb begin
        w_item.world_x    = i_world_x;
        w_item.world_y    = i_world_y;
        w_item.world_z    = i_world_z;
        w_item.ray_x      = i_ray_x;
        w_item.ray_y      = i_ray_y;
        w_item.ray_z      = i_ray_z;
        w_item.last       = i_last;
        w_item.ray_z_zero = (i_ray_z == '0);
    end

    assign o_ready = !w_full;
    assign w_push  = i_valid && !w_full;

    ppic_queue #(
        .W     ($bits(ppic_pkg::t_qitem)),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_item),
        .o_full  (w_full),
        .i_pop   (i_pop),
        .o_valid (o_head_valid),
        .o_data  (o_head)
    );
endmodule

// File: hdl/ppic_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing.
module ppic_div #(
    parameter int NUM_W = 59,
    parameter int DEN_W = 35
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quot;
    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_diff;

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign o_done   = r_done;
    assign o_quot   = r_quot;

    // Datapath: trial subtraction of the divisor from the shifted remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            if (!w_diff[DEN_W]) begin
                r_rem  <= w_diff[DEN_W-1:0];
                r_quot <= {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[DEN_W-1:0];
                r_quot <= {r_quot[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= CW'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: hdl/ppic_back.sv
// Back end: transforms, projects and scores one queued correspondence at a time.
// Depends on ppic_pkg and ppic_div.
module ppic_back #(
    parameter int MAX_POINTS = ppic_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppic_pkg::t_cfg                i_cfg,
    input  logic                          i_head_valid,
    input  ppic_pkg::t_qitem              i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ppic_pkg::ERR_W-1:0]    o_error_sq,
    output logic                          o_behind_camera,
    output logic                          o_inlier,
    output logic [ppic_pkg::CNT_W-1:0]    o_inlier_total,
    output logic                          o_set_done
);
    localparam int CNT_W = ppic_pkg::CNT_W;
    localparam logic [CNT_W-1:0] CNT_CAP = (MAX_POINTS < ppic_pkg::CNT_FIELD_MAX)
        ? CNT_W'(MAX_POINTS) : CNT_W'(ppic_pkg::CNT_FIELD_MAX);

    ppic_pkg::t_bstate r_state;
    ppic_pkg::t_bstate n_state;

    logic signed [ppic_pkg::PROD_W-1:0]  r_prod [3][3];
    logic signed [ppic_pkg::P_W-1:0]     r_p [3];
    logic signed [ppic_pkg::DPROD_W-1:0] r_dprod [3];
    logic signed [ppic_pkg::Q_W-1:0]     r_q [4];
    logic [1:0]                          r_dsel;
    logic [31:0]                         r_ax;
    logic [31:0]                         r_ay;
    logic                                r_big;
    logic [ppic_pkg::SQ_W-1:0]           r_sx;
    logic [ppic_pkg::SQ_W-1:0]           r_sy;
    logic [2*ppic_pkg::THR_W-1:0]        r_thr2;
    logic [ppic_pkg::ERR_W-1:0]          r_err;
    logic                                r_behind;
    logic                                r_inl;
    logic [CNT_W-1:0]                    r_count;
    logic [CNT_W-1:0]                    n_count;
    logic                                r_out_valid;
    logic [ppic_pkg::ERR_W-1:0]          r_out_err;
    logic                                r_out_behind;
    logic                                r_out_inl;
    logic [CNT_W-1:0]                    r_out_total;
    logic                                r_out_done;

    logic signed [ppic_pkg::WORLD_W-1:0] w_world [3];
    logic signed [ppic_pkg::RAY_W-1:0]   w_ray [3];
    logic [ppic_pkg::ROW_W-1:0]          w_row [3];
    logic signed [ppic_pkg::TRANS_W-1:0] w_trans [3];
    logic signed [ppic_pkg::ACC_W-1:0]   w_acc [3];
    logic signed [ppic_pkg::DOT_W-1:0]   w_dot;
    logic                                w_div_start;
    logic                                w_div_done;
    logic [ppic_pkg::NUM_W-1:0]          w_div_num;
    logic [ppic_pkg::DEN_W-1:0]          w_div_den;
    logic [ppic_pkg::NUM_W-1:0]          w_div_quot;
    logic                                w_div_neg;
    logic signed [ppic_pkg::P_W-1:0]     w_nsrc;
    logic signed [ppic_pkg::P_W-1:0]     w_dsrc;
    logic [ppic_pkg::P_W-1:0]            w_nmag;
    logic [ppic_pkg::P_W-1:0]            w_dmag;
    logic signed [ppic_pkg::Q_W-1:0]     w_qs;
    logic signed [ppic_pkg::DX_W-1:0]    w_dx;
    logic signed [ppic_pkg::DX_W-1:0]    w_dy;
    logic [ppic_pkg::DX_W-1:0]           w_adx;
    logic [ppic_pkg::DX_W-1:0]           w_ady;
    logic [ppic_pkg::SQ_W:0]             w_s;
    logic                                w_emit;

    // Operand views of the queue head and the pose.
    always_comb begin
        w_world[0] = i_head.world_x;
        w_world[1] = i_head.world_y;
        w_world[2] = i_head.world_z;
        w_ray[0]   = i_head.ray_x;
        w_ray[1]   = i_head.ray_y;
        w_ray[2]   = i_head.ray_z;
        w_row[0]   = i_cfg.rot_row0;
        w_row[1]   = i_cfg.rot_row1;
        w_row[2]   = i_cfg.rot_row2;
        w_trans[0] = i_cfg.trans_x;
        w_trans[1] = i_cfg.trans_y;
        w_trans[2] = i_cfg.trans_z;
    end

    // Row sums in Q.30, translation scaled up by 2^14.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_acc[i] = ppic_pkg::ACC_W'(r_prod[i][0]) + ppic_pkg::ACC_W'(r_prod[i][1])
                     + ppic_pkg::ACC_W'(r_prod[i][2])
                     + (ppic_pkg::ACC_W'(w_trans[i]) <<< 14);
        end
        w_dot = ppic_pkg::DOT_W'(r_dprod[0]) + ppic_pkg::DOT_W'(r_dprod[1])
              + ppic_pkg::DOT_W'(r_dprod[2]);
    end

    // Divider operands: x and y of the point over its z, then of the ray over its z.
    always_comb begin
        case (r_dsel)
            2'd0: begin
                w_nsrc = r_p[0];
                w_dsrc = r_p[2];
            end
            2'd1: begin
                w_nsrc = r_p[1];
                w_dsrc = r_p[2];
            end
            2'd2: begin
                w_nsrc = ppic_pkg::P_W'(w_ray[0]);
                w_dsrc = ppic_pkg::P_W'(w_ray[2]);
            end
            default: begin
                w_nsrc = ppic_pkg::P_W'(w_ray[1]);
                w_dsrc = ppic_pkg::P_W'(w_ray[2]);
            end
        endcase
        w_nmag    = w_nsrc[ppic_pkg::P_W-1] ? -w_nsrc : w_nsrc;
        w_dmag    = w_dsrc[ppic_pkg::P_W-1] ? -w_dsrc : w_dsrc;
        w_div_num = {w_nmag, 24'd0};
        w_div_den = w_dmag;
        w_div_neg = w_nsrc[ppic_pkg::P_W-1] ^ w_dsrc[ppic_pkg::P_W-1];
        w_qs      = w_div_neg ? -$signed({1'b0, w_div_quot}) : $signed({1'b0, w_div_quot});
    end

    // Projected differences and the final sum of squares.
    always_comb begin
        w_dx  = ppic_pkg::DX_W'(r_q[0]) - ppic_pkg::DX_W'(r_q[2]);
        w_dy  = ppic_pkg::DX_W'(r_q[1]) - ppic_pkg::DX_W'(r_q[3]);
        w_adx = w_dx[ppic_pkg::DX_W-1] ? -w_dx : w_dx;
        w_ady = w_dy[ppic_pkg::DX_W-1] ? -w_dy : w_dy;
        w_s   = {1'b0, r_sx} + {1'b0, r_sy};
    end

    // The result register is free, or frees at this edge.
    assign w_emit = (r_state == ppic_pkg::B_EMIT) && (!r_out_valid || i_ready);

    // Next state and control strobes.
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        o_pop       = 1'b0;
        case (r_state)
            ppic_pkg::B_IDLE: begin
                if (i_head_valid) n_state = ppic_pkg::B_MUL;
            end
            ppic_pkg::B_MUL:  n_state = ppic_pkg::B_SUM;
            ppic_pkg::B_SUM:  n_state = ppic_pkg::B_DOTM;
            ppic_pkg::B_DOTM: n_state = ppic_pkg::B_DOTS;
            ppic_pkg::B_DOTS: begin
                if (w_dot[ppic_pkg::DOT_W-1] || r_p[2] == '0 || i_head.ray_z_zero) begin
                    n_state = ppic_pkg::B_EMIT;
                end else begin
                    n_state = ppic_pkg::B_DIVGO;
                end
            end
            ppic_pkg::B_DIVGO: begin
                w_div_start = 1'b1;
                n_state     = ppic_pkg::B_DIVW;
            end
            ppic_pkg::B_DIVW: begin
                if (w_div_done) begin
                    n_state = (r_dsel == 2'd3) ? ppic_pkg::B_DIFF : ppic_pkg::B_DIVGO;
                end
            end
            ppic_pkg::B_DIFF: n_state = ppic_pkg::B_SQ;
            ppic_pkg::B_SQ:   n_state = ppic_pkg::B_FIN;
            ppic_pkg::B_FIN:  n_state = ppic_pkg::B_EMIT;
            ppic_pkg::B_EMIT: begin
                if (w_emit) begin
                    o_pop   = 1'b1;
                    n_state = ppic_pkg::B_IDLE;
                end
            end
            default: n_state = ppic_pkg::B_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppic_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Arithmetic registers, one step per state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ppic_pkg::B_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_prod[i][j] <= $signed(w_row[i][16*j +: ppic_pkg::ROT_W]) * w_world[j];
                    end
                end
            end
            ppic_pkg::B_SUM: begin
                for (int i = 0; i < 3; i++) begin
                    r_p[i] <= w_acc[i][ppic_pkg::P_W+13:14];
                end
            end
            ppic_pkg::B_DOTM: begin
                for (int i = 0; i < 3; i++) begin
                    r_dprod[i] <= r_p[i] * w_ray[i];
                end
            end
            ppic_pkg::B_DOTS: begin
                r_dsel   <= 2'd0;
                r_err    <= ppic_pkg::ERR_MAX;
                r_inl    <= 1'b0;
                r_behind <= w_dot[ppic_pkg::DOT_W-1];
            end
            ppic_pkg::B_DIVW: begin
                if (w_div_done) begin
                    r_q[r_dsel] <= w_qs;
                    r_dsel      <= r_dsel + 1'b1;
                end
            end
            ppic_pkg::B_DIFF: begin
                r_ax  <= w_adx[31:0];
                r_ay  <= w_ady[31:0];
                r_big <= (w_adx[ppic_pkg::DX_W-1:32] != '0)
                      || (w_ady[ppic_pkg::DX_W-1:32] != '0);
            end
            ppic_pkg::B_SQ: begin
                r_sx   <= r_ax * r_ax;
                r_sy   <= r_ay * r_ay;
                r_thr2 <= i_cfg.threshold * i_cfg.threshold;
            end
            ppic_pkg::B_FIN: begin
                if (r_big || w_s[ppic_pkg::SQ_W]) begin
                    r_err <= ppic_pkg::ERR_MAX;
                    r_inl <= 1'b0;
                end else begin
                    r_err <= w_s[ppic_pkg::SQ_W-1:16];
                    r_inl <= (w_s[ppic_pkg::SQ_W-1:0] < ppic_pkg::SQ_W'(r_thr2));
                end
            end
            default: begin
            end
        endcase
    end

    // Running count saturates at the cap.
    assign n_count = (r_inl && r_count < CNT_CAP) ? r_count + 1'b1 : r_count;

    // Counter and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_count     <= i_head.last ? '0 : n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_err    <= r_err;
            r_out_behind <= r_behind;
            r_out_inl    <= r_inl;
            r_out_total  <= n_count;
            r_out_done   <= i_head.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_error_sq      = r_out_err;
    assign o_behind_camera = r_out_behind;
    assign o_inlier        = r_out_inl;
    assign o_inlier_total  = r_out_total;
    assign o_set_done      = r_out_done;

    ppic_div #(
        .NUM_W (ppic_pkg::NUM_W),
        .DEN_W (ppic_pkg::DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // A point behind the camera always carries the saturated error and no inlier.
    a_behind_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_behind_camera |-> !o_inlier && o_error_sq == ppic_pkg::ERR_MAX)
        else $error("behind-camera result not saturated");

    // An inlier has an error below the 24-bit threshold squared, so within the low 32 bits, and a nonzero total.
    a_inlier_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inlier |-> o_error_sq[ppic_pkg::ERR_W-1:32] == '0 && o_inlier_total != '0)
        else $error("inlier with oversized error or zero total");

    // The queue head is only released when a result is stored.
    a_pop_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid && r_state == ppic_pkg::B_IDLE)
        else $error("item released without a result");

    // The divider is only started while a projection is in progress.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> i_head_valid && !i_head.ray_z_zero && r_p[2] != '0)
        else $error("divider started without a valid divisor");
endmodule

// File: hdl/pose_reprojection_inlier_counter_unit.sv
// Top level of the pose reprojection inlier counter: register file and the two ends.
// Depends on ppic_pkg, ppic_front and ppic_back.

// Each correspondence (world point, observed ray, last flag) gives exactly one
// result. A two-entry queue takes items while the engine works; the engine
// handles one item at a time. A point that lies behind the camera, or has zero
// depth, skips the divider; any other item spends most of its time in the
// shared one-bit-per-cycle divider that forms the four projections, 59 steps
// each. The result waits in an output register, so the next item starts
// while it is still unread. Pose and threshold sit in 64-bit registers at byte
// addresses 0 through 48 in steps of 8 and are to be written by the user only
// while the block is idle; the block itself does not enforce it.
module pose_reprojection_inlier_counter_unit #(
    parameter int MAX_POINTS = ppic_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppic_pkg::ADDR_W-1:0]         paddr,
    input  logic [ppic_pkg::DATA_W-1:0]         pwdata,
    output logic [ppic_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ppic_pkg::WORLD_W-1:0] i_world_x,
    input  logic signed [ppic_pkg::WORLD_W-1:0] i_world_y,
    input  logic signed [ppic_pkg::WORLD_W-1:0] i_world_z,
    input  logic signed [ppic_pkg::RAY_W-1:0]   i_ray_x,
    input  logic signed [ppic_pkg::RAY_W-1:0]   i_ray_y,
    input  logic signed [ppic_pkg::RAY_W-1:0]   i_ray_z,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ppic_pkg::ERR_W-1:0]          o_error_sq,
    output logic                                o_behind_camera,
    output logic                                o_inlier,
    output logic [ppic_pkg::CNT_W-1:0]          o_inlier_total,
    output logic                                o_set_done
);
    ppic_pkg::t_cfg   r_cfg;
    ppic_pkg::t_qitem w_head;
    ppic_pkg::t_reg_idx w_idx;
    logic             w_head_valid;
    logic             w_pop;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = ppic_pkg::t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_row0  <= ppic_pkg::ROW_W'(48'h0000_0000_4000);
            r_cfg.rot_row1  <= ppic_pkg::ROW_W'(48'h0000_4000_0000);
            r_cfg.rot_row2  <= ppic_pkg::ROW_W'(48'h4000_0000_0000);
            r_cfg.trans_x   <= '0;
            r_cfg.trans_y   <= '0;
            r_cfg.trans_z   <= '0;
            r_cfg.threshold <= ppic_pkg::THR_W'(167772);
        end else if (w_wr) begin
            case (w_idx)
                ppic_pkg::REG_ROT_ROW0:  r_cfg.rot_row0  <= pwdata[ppic_pkg::ROW_W-1:0];
                ppic_pkg::REG_ROT_ROW1:  r_cfg.rot_row1  <= pwdata[ppic_pkg::ROW_W-1:0];
                ppic_pkg::REG_ROT_ROW2:  r_cfg.rot_row2  <= pwdata[ppic_pkg::ROW_W-1:0];
                ppic_pkg::REG_TRANS_X:   r_cfg.trans_x   <= pwdata[ppic_pkg::TRANS_W-1:0];
                ppic_pkg::REG_TRANS_Y:   r_cfg.trans_y   <= pwdata[ppic_pkg::TRANS_W-1:0];
                ppic_pkg::REG_TRANS_Z:   r_cfg.trans_z   <= pwdata[ppic_pkg::TRANS_W-1:0];
                ppic_pkg::REG_THRESHOLD: r_cfg.threshold <= pwdata[ppic_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back of the register selected by the address.
    always_comb begin
        case (w_idx)
            ppic_pkg::REG_ROT_ROW0:  prdata = ppic_pkg::DATA_W'(r_cfg.rot_row0);
            ppic_pkg::REG_ROT_ROW1:  prdata = ppic_pkg::DATA_W'(r_cfg.rot_row1);
            ppic_pkg::REG_ROT_ROW2:  prdata = ppic_pkg::DATA_W'(r_cfg.rot_row2);
            ppic_pkg::REG_TRANS_X:   prdata = ppic_pkg::DATA_W'(unsigned'(r_cfg.trans_x));
            ppic_pkg::REG_TRANS_Y:   prdata = ppic_pkg::DATA_W'(unsigned'(r_cfg.trans_y));
            ppic_pkg::REG_TRANS_Z:   prdata = ppic_pkg::DATA_W'(unsigned'(r_cfg.trans_z));
            ppic_pkg::REG_THRESHOLD: prdata = ppic_pkg::DATA_W'(r_cfg.threshold);
            default:                 prdata = '0;
        endcase
    end

    ppic_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_world_x    (i_world_x),
        .i_world_y    (i_world_y),
        .i_world_z    (i_world_z),
        .i_ray_x      (i_ray_x),
        .i_ray_y      (i_ray_y),
        .i_ray_z      (i_ray_z),
        .i_last       (i_last),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    ppic_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_error_sq      (o_error_sq),
        .o_behind_camera (o_behind_camera),
        .o_inlier        (o_inlier),
        .o_inlier_total  (o_inlier_total),
        .o_set_done      (o_set_done)
    );
endmodule

// File: bench/tb.sv
// Self-checking bench for pose_reprojection_inlier_counter_unit: directed rows, then random
// correspondences under several pose and threshold settings, with random gaps on both sides but in one phase.
// Depends on ppic_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
    import ppic_pkg::*;

    typedef struct {
        logic signed [WORLD_W-1:0] wx, wy, wz;
        logic signed [RAY_W-1:0]   rx, ry, rz;
        logic                      last;
    } t_corr;

    typedef struct {
        logic [ERR_W-1:0] err;
        logic             behind;
        logic             inl;
        logic [CNT_W-1:0] total;
        logic             done;
    } t_score;

    typedef struct {
        t_corr  c;
        bit     typed;
        t_score want;
    } t_dir_row;

    localparam longint CYCLE_LIMIT = 6000000;
    localparam int     SETTLE      = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [WORLD_W-1:0] i_world_x = '0, i_world_y = '0, i_world_z = '0;
    logic signed [RAY_W-1:0]   i_ray_x = '0, i_ray_y = '0, i_ray_z = '0;
    logic i_last = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [ERR_W-1:0] o_error_sq;
    logic o_behind_camera, o_inlier, o_set_done;
    logic [CNT_W-1:0] o_inlier_total;

    pose_reprojection_inlier_counter_unit dut (.*);

    // Shadow copy of the pose, the threshold and the running inlier count.
    logic [ROW_W-1:0]          pose_row [3];
    logic signed [TRANS_W-1:0] pose_t [3];
    logic [THR_W-1:0]          thr_q;
    int unsigned               inlier_cnt;

    t_score   pending_scores[$];
    t_dir_row dir_rows[$];
    bit       failed = 1'b0;
    bit       stim_done = 1'b0;
    bit       no_gaps = 1'b0;
    longint   cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // One row of the pose applied to the point, reduced from Q.30 to Q.16 by a floor shift.
    function automatic longint pose_axis(int k, longint wx, longint wy, longint wz);
        longint r0 = longint'($signed(pose_row[k][15:0]));
        longint r1 = longint'($signed(pose_row[k][31:16]));
        longint r2 = longint'($signed(pose_row[k][47:32]));
        longint acc = r0 * wx + r1 * wy + r2 * wz + longint'(pose_t[k]) * 16384;
        return acc >>> 14;
    endfunction

    function automatic bit [63:0] mag64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Q.24 projection quotient, truncated toward zero.
    function automatic longint proj_q24(longint n, longint d);
        bit [63:0] q = (mag64(n) << 24) / mag64(d);
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // Expected score of one correspondence; advances the inlier count.
    function automatic t_score score_corr(t_corr c);
        t_score s;
        longint px, py, pz, rx, ry, rz, dot, dx, dy;
        bit [63:0] ax, ay, sx, sy, sum, thr;
        px = pose_axis(0, c.wx, c.wy, c.wz);
        py = pose_axis(1, c.wx, c.wy, c.wz);
        pz = pose_axis(2, c.wx, c.wy, c.wz);
        rx = c.rx;
        ry = c.ry;
        rz = c.rz;
        s.err = ERR_MAX;
        s.behind = 1'b0;
        s.inl = 1'b0;
        dot = px * rx + py * ry + pz * rz;
        if (dot < 0) begin
            s.behind = 1'b1;
        end else if (pz != 0 && rz != 0) begin
            dx = proj_q24(px, pz) - proj_q24(rx, rz);
            dy = proj_q24(py, pz) - proj_q24(ry, rz);
            ax = mag64(dx);
            ay = mag64(dy);
            if (ax < 64'h1_0000_0000 && ay < 64'h1_0000_0000) begin
                sx = ax * ax;
                sy = ay * ay;
                sum = sx + sy;
                if (sum >= sx) begin
                    thr = 64'(thr_q);
                    s.err = sum[63:16];
                    s.inl = sum < thr * thr;
                end
            end
        end
        if (s.inl && inlier_cnt < 65536)
            inlier_cnt++;
        s.total = CNT_W'(inlier_cnt);
        s.done = c.last;
        if (c.last)
            inlier_cnt = 0;
        return s;
    endfunction

    // Register write over the configuration port, mirrored into the shadow copy.
    // The bus returns to idle before the next access.
    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_ROT_ROW0:  pose_row[0] = val[ROW_W-1:0];
            REG_ROT_ROW1:  pose_row[1] = val[ROW_W-1:0];
            REG_ROT_ROW2:  pose_row[2] = val[ROW_W-1:0];
            REG_TRANS_X:   pose_t[0] = val[TRANS_W-1:0];
            REG_TRANS_Y:   pose_t[1] = val[TRANS_W-1:0];
            REG_TRANS_Z:   pose_t[2] = val[TRANS_W-1:0];
            REG_THRESHOLD: thr_q = val[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_pose(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                              logic [ROW_W-1:0] r2, logic [TRANS_W-1:0] tx,
                              logic [TRANS_W-1:0] ty, logic [TRANS_W-1:0] tz,
                              logic [THR_W-1:0] thr);
        write_reg(REG_ROT_ROW0, 64'(r0));
        write_reg(REG_ROT_ROW1, 64'(r1));
        write_reg(REG_ROT_ROW2, 64'(r2));
        write_reg(REG_TRANS_X, 64'(tx));
        write_reg(REG_TRANS_Y, 64'(ty));
        write_reg(REG_TRANS_Z, 64'(tz));
        write_reg(REG_THRESHOLD, 64'(thr));
    endtask

    // Waits until every expected result has come back, then lets the engine settle.
    task automatic drain();
        while (pending_scores.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(20, 100);
        return $urandom_range(0, 3);
    endfunction

    // Offers one item and holds it until accepted; the expected score is queued on acceptance.
    task automatic offer(t_corr c, bit typed, t_score want);
        t_score s;
        int gap;
        i_valid   <= 1'b1;
        i_world_x <= c.wx;
        i_world_y <= c.wy;
        i_world_z <= c.wz;
        i_ray_x   <= c.rx;
        i_ray_y   <= c.ry;
        i_ray_z   <= c.rz;
        i_last    <= c.last;
        do @(posedge i_clk); while (!o_ready);
        s = score_corr(c);
        if (typed)
            s = want;
        pending_scores.insert(pending_scores.size(), s);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [RAY_W-1:0] rand_ray();
        return RAY_W'($urandom);
    endfunction

    // Random correspondence: mostly a ray aimed near the transformed point, the rest
    // mirrored behind the camera, zero depth, or plain noise.
    function automatic t_corr rand_corr();
        t_corr c;
        longint p[3];
        int k, kind;
        kind = $urandom_range(0, 99);
        c.last = ($urandom_range(0, 19) == 0);
        if (kind < 25) begin
            c.wx = $urandom;
            c.wy = $urandom;
            c.wz = $urandom;
            c.rx = rand_ray();
            c.ry = rand_ray();
            c.rz = ($urandom_range(0, 9) == 0) ? '0 : rand_ray();
            return c;
        end
        c.wx = $signed(WORLD_W'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
        c.wy = $signed(WORLD_W'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
        c.wz = 32'sd65536 + $signed(WORLD_W'($urandom_range(0, 32'h01FF_FFFF)));
        for (int i = 0; i < 3; i++)
            p[i] = pose_axis(i, c.wx, c.wy, c.wz);
        k = 0;
        while (k < 40 && ((p[0] >>> k) >= 2**22 || (p[0] >>> k) < -(2**22) ||
               (p[1] >>> k) >= 2**22 || (p[1] >>> k) < -(2**22) ||
               (p[2] >>> k) >= 2**22 || (p[2] >>> k) < -(2**22)))
            k++;
        c.rx = RAY_W'((p[0] >>> k) + longint'($urandom_range(0, 6)) - 3);
        c.ry = RAY_W'((p[1] >>> k) + longint'($urandom_range(0, 6)) - 3);
        c.rz = RAY_W'(p[2] >>> k);
        if (kind < 40) begin
            c.rx = -c.rx;
            c.ry = -c.ry;
            c.rz = -c.rz;
        end else if (kind < 45) begin
            c.rz = '0;
        end
        return c;
    endfunction

    function automatic void add_row(int wx, int wy, int wz, int rx, int ry, int rz,
                                    bit last, bit typed, logic [ERR_W-1:0] err,
                                    bit behind, bit inl, int total);
        t_dir_row r;
        r.c = '{wx, wy, wz, RAY_W'(rx), RAY_W'(ry), RAY_W'(rz), last};
        r.typed = typed;
        r.want = '{err, behind, inl, CNT_W'(total), last};
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Receiver: ready held high or low over stretches of random length.
    initial begin
        @(posedge i_rst_n);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!no_gaps) begin
                i_ready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                        : $urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_scores.size() == 0) begin
                $error("result with no expectation waiting");
                failed = 1'b1;
            end else begin
                t_score w;
                w = pending_scores.pop_front();
                if (o_error_sq !== w.err) begin
                    $error("error_sq: expected %h, got %h", w.err, o_error_sq);
                    failed = 1'b1;
                end
                if (o_behind_camera !== w.behind) begin
                    $error("behind_camera: expected %b, got %b", w.behind, o_behind_camera);
                    failed = 1'b1;
                end
                if (o_inlier !== w.inl) begin
                    $error("inlier: expected %b, got %b", w.inl, o_inlier);
                    failed = 1'b1;
                end
                if (o_inlier_total !== w.total) begin
                    $error("inlier_total: expected %0d, got %0d", w.total, o_inlier_total);
                    failed = 1'b1;
                end
                if (o_set_done !== w.done) begin
                    $error("set_done: expected %b, got %b", w.done, o_set_done);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, then random phases under new settings.
    initial begin
        t_score none;
        none = '{default: '0};
        pose_row[0] = 48'h4000;
        pose_row[1] = 48'h4000 << 16;
        pose_row[2] = 48'h4000 << 32;
        pose_t = '{default: '0};
        thr_q = 24'd167772;
        inlier_cnt = 0;

        // Point on the optical axis, seen straight on: zero error, an inlier.
        add_row(0, 0, 65536, 0, 0, 1 << 20, 0, 1, '0, 0, 1, 1);
        // Ray pointing away from the point: behind the camera.
        add_row(0, 0, 65536, 0, 0, -(1 << 20), 0, 1, ERR_MAX, 1, 0, 1);
        // Point at the origin: zero depth after the pose.
        add_row(0, 0, 0, 0, 0, 1 << 20, 0, 1, ERR_MAX, 0, 0, 1);
        // Ray with zero depth.
        add_row(0, 0, 65536, 0, 0, 0, 1, 1, ERR_MAX, 0, 0, 1);
        // Field extremes and near misses, checked against the predictor.
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8388607, 8388607, 8388607,
                0, 0, '0, 0, 0, 0);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -8388608, -8388608, -8388608,
                0, 0, '0, 0, 0, 0);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 1, 8388607, -8388608, 1, 0, 0, '0, 0, 0, 0);
        add_row(65536, 0, 65536, 1 << 20, 0, 1 << 20, 0, 0, '0, 0, 0, 0);
        add_row(655, 0, 65536, 0, 0, 1 << 20, 0, 0, '0, 0, 0, 0);
        add_row(656, 0, 65536, 0, 0, 1 << 20, 0, 0, '0, 0, 0, 0);
        add_row(0, 32'h7FFF_FFFF, 1, 0, 0, 1 << 20, 0, 0, '0, 0, 0, 0);
        add_row(-1, -1, -1, -1, -1, -1, 1, 0, '0, 0, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            offer(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
        i_valid <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: write_pose({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                              $urandom, $urandom, $urandom, $urandom);
                1: write_pose('1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1);
                2: write_pose('0, '0, '0, '0, '0, '0, '0);
                3: write_pose(48'h4000, 48'h4000 << 16, 48'h4000 << 32,
                              $urandom_range(0, 32'h0003_FFFF),
                              $urandom_range(0, 32'h0003_FFFF), 32'h0001_0000,
                              $urandom_range(0, 24'h0F_FFFF));
                4: write_pose({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                              $urandom_range(0, 32'h000F_FFFF), $urandom,
                              $urandom_range(0, 32'h000F_FFFF), $urandom);
                default: write_pose(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
            endcase
            // Junk access to the spare register slot, which the block must ignore.
            write_reg(REG_UNUSED, {$urandom, $urandom});
            no_gaps = (ph == 3);
            for (int n = 0; n < 323; n++)
                offer(rand_corr(), 1'b0, none);
            i_valid <= 1'b0;
            no_gaps = 1'b0;
        end

        while (pending_scores.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
